### hdl/ikve_pkg.sv
// Shared types, constants and helpers for the INI key/value extractor.
// No dependencies; ikve_cfg_regs, ikve_step and the extractor unit refer to it by scoped names.
package ikve_pkg;

  localparam int unsigned MAX_KEY_CHARS   = 16;
  localparam int unsigned MAX_VALUE_CAP   = 4096;
  localparam int unsigned KEY_LEN_W       = 5;
  localparam int unsigned CAP_W           = 13;
  localparam int unsigned VCOUNT_W        = 12;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEC_KEY_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_KEY_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_KEY_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_KEY_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_CAP   = 3'd6;

  // result status codes
  localparam logic [1:0] STATUS_FOUND       = 2'd0;
  localparam logic [1:0] STATUS_NO_SECTION  = 2'd1;
  localparam logic [1:0] STATUS_NO_PROPERTY = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {
    PH_SECTION  = 2'd0,
    PH_PROPERTY = 2'd1,
    PH_VALUE    = 2'd2,
    PH_DONE     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    LS_START   = 2'd0,
    LS_COMPARE = 2'd1,
    LS_BYPASS  = 2'd2,
    LS_COPY    = 2'd3
  } line_e;

  typedef logic [MAX_KEY_CHARS-1:0][7:0] key_t;

  // configuration with lengths and capacity already clamped
  typedef struct packed {
    key_t                 sec_key;
    logic [KEY_LEN_W-1:0] sec_len;
    key_t                 prop_key;
    logic [KEY_LEN_W-1:0] prop_len;
    logic [VCOUNT_W-1:0]  val_limit;
  } cfg_t;

  typedef struct packed {
    phase_e               phase;
    line_e                ls;
    logic [KEY_LEN_W-1:0] mc;
    logic [VCOUNT_W-1:0]  vc;
  } state_t;

  typedef struct packed {
    logic       value_valid;
    logic [7:0] value_byte;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

endpackage

### hdl/ikve_if.sv
// Valid/ready channels for file bytes in and extracted words out.
// Depends on nothing but plain logic types.
interface ikve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface ikve_out_if;
  logic       valid;
  logic       ready;
  logic       value_valid;
  logic [7:0] value_byte;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, value_valid, value_byte, done_res, status, input ready);
  modport sink   (input valid, value_valid, value_byte, done_res, status, output ready);
endinterface

### hdl/ikve_cfg_regs.sv
// Configuration registers of the extractor, with length and capacity clamping.
// Depends on ikve_pkg.
module ikve_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ikve_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ikve_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output ikve_pkg::cfg_t                       cfg_o
);

  logic [63:0]                       sec_lo_q, sec_hi_q, prop_lo_q, prop_hi_q;
  logic [ikve_pkg::KEY_LEN_W-1:0]    sec_len_q, prop_len_q;
  logic [ikve_pkg::CAP_W-1:0]        cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_lo_q   <= '0;
      sec_hi_q   <= '0;
      sec_len_q  <= '0;
      prop_lo_q  <= '0;
      prop_hi_q  <= '0;
      prop_len_q <= ikve_pkg::KEY_LEN_W'(1);
      cap_q      <= ikve_pkg::CAP_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ikve_pkg::REG_SEC_KEY_LO:  sec_lo_q   <= cfg_data_i;
        ikve_pkg::REG_SEC_KEY_HI:  sec_hi_q   <= cfg_data_i;
        ikve_pkg::REG_SEC_LEN:     sec_len_q  <= cfg_data_i[ikve_pkg::KEY_LEN_W-1:0];
        ikve_pkg::REG_PROP_KEY_LO: prop_lo_q  <= cfg_data_i;
        ikve_pkg::REG_PROP_KEY_HI: prop_hi_q  <= cfg_data_i;
        ikve_pkg::REG_PROP_LEN:    prop_len_q <= cfg_data_i[ikve_pkg::KEY_LEN_W-1:0];
        ikve_pkg::REG_VALUE_CAP:   cap_q      <= cfg_data_i[ikve_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.sec_key  = {sec_hi_q, sec_lo_q};
    cfg_o.prop_key = {prop_hi_q, prop_lo_q};
    cfg_o.sec_len  = (sec_len_q > ikve_pkg::KEY_LEN_W'(ikve_pkg::MAX_KEY_CHARS))
                   ? ikve_pkg::KEY_LEN_W'(ikve_pkg::MAX_KEY_CHARS) : sec_len_q;
    cfg_o.prop_len = (prop_len_q > ikve_pkg::KEY_LEN_W'(ikve_pkg::MAX_KEY_CHARS))
                   ? ikve_pkg::KEY_LEN_W'(ikve_pkg::MAX_KEY_CHARS) : prop_len_q;
    // a capacity of zero behaves as one: no characters fit
    if (cap_q == '0) begin
      cfg_o.val_limit = '0;
    end else if (cap_q > ikve_pkg::CAP_W'(ikve_pkg::MAX_VALUE_CAP)) begin
      cfg_o.val_limit = ikve_pkg::VCOUNT_W'(ikve_pkg::MAX_VALUE_CAP - 1);
    end else begin
      cfg_o.val_limit = ikve_pkg::VCOUNT_W'(cap_q - ikve_pkg::CAP_W'(1));
    end
  end

endmodule

### hdl/ikve_step.sv
// Per-byte update of the search state and result word for the extractor.
// Depends on ikve_pkg.
module ikve_step (
  input  ikve_pkg::cfg_t   cfg_i,
  input  ikve_pkg::state_t state_i,
  input  logic [7:0]       byte_i,
  input  logic             first_i,
  input  logic             last_i,
  output ikve_pkg::state_t state_o,
  output logic             emit_o,
  output ikve_pkg::res_t   res_o
);

  ikve_pkg::state_t s0;
  logic [7:0]       c_fold;
  logic             sec_match, prop_match;

  // a new file restarts the search before the byte is looked at
  always_comb begin
    s0 = state_i;
    if (first_i) begin
      s0.phase = (cfg_i.sec_len != '0) ? ikve_pkg::PH_SECTION : ikve_pkg::PH_PROPERTY;
      s0.ls    = ikve_pkg::LS_START;
      s0.mc    = '0;
      s0.vc    = '0;
    end
  end

  assign c_fold     = ikve_pkg::fold_char(byte_i);
  assign sec_match  = (s0.mc < cfg_i.sec_len) &&
                      (c_fold == ikve_pkg::fold_char(cfg_i.sec_key[s0.mc[3:0]]));
  assign prop_match = (s0.mc < cfg_i.prop_len) &&
                      (c_fold == ikve_pkg::fold_char(cfg_i.prop_key[s0.mc[3:0]]));

  always_comb begin
    ikve_pkg::state_t s;
    logic             done, valid, next_sec;
    logic [1:0]       status;
    s        = s0;
    done     = 1'b0;
    valid    = 1'b0;
    next_sec = 1'b0;
    status   = ikve_pkg::STATUS_FOUND;
    if (s0.phase != ikve_pkg::PH_DONE) begin
      case (s0.phase)
        ikve_pkg::PH_SECTION: begin
          if (s.ls == ikve_pkg::LS_START) begin
            if (byte_i == ikve_pkg::CH_SEMI) s.ls = ikve_pkg::LS_BYPASS;
            else if (byte_i != ikve_pkg::CH_SPACE) s.ls = ikve_pkg::LS_COMPARE;
          end
          if (s.ls == ikve_pkg::LS_COMPARE) begin
            if (byte_i == ikve_pkg::CH_LF) begin
              if (s.mc == cfg_i.sec_len) s.phase = ikve_pkg::PH_PROPERTY;
              s.mc = '0;
              s.ls = ikve_pkg::LS_START;
            end else if (byte_i == ikve_pkg::CH_EQUAL) begin
              s.mc = '0;
              s.ls = ikve_pkg::LS_BYPASS;
            end else if (sec_match) begin
              s.mc = s.mc + ikve_pkg::KEY_LEN_W'(1);
            end else if (byte_i != ikve_pkg::CH_SPACE && byte_i != ikve_pkg::CH_CR) begin
              s.mc = '0;
            end
          end else if (s.ls == ikve_pkg::LS_BYPASS && byte_i == ikve_pkg::CH_LF) begin
            s.ls = ikve_pkg::LS_START;
          end
        end
        ikve_pkg::PH_PROPERTY: begin
          // with a section key set, a section header ends the search, leaving line state untouched
          if (s.ls == ikve_pkg::LS_START && byte_i == ikve_pkg::CH_LBRACK &&
              cfg_i.sec_len != '0) begin
            next_sec = 1'b1;
            done     = 1'b1;
            status   = ikve_pkg::STATUS_NO_PROPERTY;
          end else begin
            if (s.ls == ikve_pkg::LS_START) begin
              if (byte_i == ikve_pkg::CH_SEMI) s.ls = ikve_pkg::LS_BYPASS;
              else if (byte_i != ikve_pkg::CH_SPACE) s.ls = ikve_pkg::LS_COMPARE;
            end
            if (s.ls == ikve_pkg::LS_COMPARE) begin
              if (byte_i == ikve_pkg::CH_EQUAL) begin
                if (s.mc == cfg_i.prop_len) begin
                  s.phase = ikve_pkg::PH_VALUE;
                  s.ls    = ikve_pkg::LS_START;
                end else begin
                  s.ls = ikve_pkg::LS_BYPASS;
                end
                s.mc = '0;
              end else if (byte_i == ikve_pkg::CH_LF) begin
                s.mc = '0;
                s.ls = ikve_pkg::LS_START;
              end else if (prop_match) begin
                s.mc = s.mc + ikve_pkg::KEY_LEN_W'(1);
              end else if (byte_i != ikve_pkg::CH_SPACE) begin
                s.mc = '0;
              end
            end else if (s.ls == ikve_pkg::LS_BYPASS && byte_i == ikve_pkg::CH_LF) begin
              s.ls = ikve_pkg::LS_START;
            end
          end
        end
        ikve_pkg::PH_VALUE: begin
          // skip leading spaces, then copy up to the newline or the capacity limit, dropping CRs
          if (s.ls == ikve_pkg::LS_START && byte_i != ikve_pkg::CH_SPACE) begin
            s.ls = ikve_pkg::LS_COPY;
          end
          if (s.ls == ikve_pkg::LS_COPY) begin
            if (byte_i == ikve_pkg::CH_LF) begin
              done = 1'b1;
            end else if (byte_i != ikve_pkg::CH_CR) begin
              if (s.vc < cfg_i.val_limit) begin
                valid = 1'b1;
                s.vc  = s.vc + ikve_pkg::VCOUNT_W'(1);
              end else begin
                done = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      if (last_i && !done) begin
        done = 1'b1;
        if (s.phase == ikve_pkg::PH_SECTION) status = ikve_pkg::STATUS_NO_SECTION;
        else if (s.phase == ikve_pkg::PH_PROPERTY) status = ikve_pkg::STATUS_NO_PROPERTY;
        else status = ikve_pkg::STATUS_FOUND;
      end
      if (done || next_sec) s.phase = ikve_pkg::PH_DONE;
    end
    state_o           = s;
    emit_o            = valid || done;
    res_o.value_valid = valid;
    res_o.value_byte  = valid ? byte_i : 8'h00;
    res_o.done_res    = done;
    res_o.status      = done ? status : ikve_pkg::STATUS_FOUND;
  end

endmodule

### hdl/ini_key_value_extractor_unit.sv
// INI key/value extractor: finds a section, then a property, and streams its value.
// A byte is taken whenever the input is ready; each accepted byte is held in the input
// register, and a word that it produces goes to the result register and is offered from
// there. While a word waits at the output the held byte waits too, and the input stalls
// only when both registers are occupied. Throughput is one byte per cycle unless the
// output stalls; the phase, line state and match/value counters are updated
// combinationally for each byte. At most one word leaves per byte: a value character, a
// final status, or both on the last character. Depends on ikve_pkg, ikve_if,
// ikve_cfg_regs and ikve_step.
module ini_key_value_extractor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ikve_in_if.sink                            in_i,
  ikve_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [ikve_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ikve_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  ikve_pkg::cfg_t   cfg;
  ikve_pkg::state_t state_q, state_d;
  ikve_pkg::res_t   res_q, res_d;
  logic             emit;
  logic             a_valid_q, a_valid_d;
  logic [7:0]       a_byte_q;
  logic             a_first_q, a_last_q;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             in_take;

  ikve_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ikve_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .byte_i  (a_byte_q),
    .first_i (a_first_q),
    .last_i  (a_last_q),
    .state_o (state_d),
    .emit_o  (emit),
    .res_o   (res_d)
  );

  // move the held byte on whenever the result register is free or draining
  assign advance     = a_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !a_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign a_valid_d   = in_take || (a_valid_q && !advance);
  assign out_valid_d = advance ? emit : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: ikve_pkg::PH_DONE, ls: ikve_pkg::LS_START, mc: '0, vc: '0};
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_byte_q  <= in_i.data_byte;
      a_first_q <= in_i.first_byte;
      a_last_q  <= in_i.last_byte;
    end
    if (advance && emit) res_q <= res_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value_valid = res_q.value_valid;
  assign out_o.value_byte  = res_q.value_byte;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.status      = res_q.status;

  // every word carries a character or a final status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.value_valid || out_o.done_res))
    else $error("result word with neither character nor status");

  // a finishing byte leaves the search closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit && res_d.done_res) |=> (state_q.phase == ikve_pkg::PH_DONE))
    else $error("search not closed after final status");

  // input stalls only with both registers occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (a_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled with free pipeline slot");

endmodule
